// ----- hw/rtl/tcq_pkg.sv -----
package tcq_pkg;

    localparam int DEF_QUEUE_DEPTH       = 16;
    localparam int DEF_MAX_PAYLOAD_BYTES = 8;
    localparam int RESULT_LIMIT          = 16;
    localparam int CNT_W                 = $clog2(RESULT_LIMIT);

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_PAST     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [31:0] due;
        logic [15:0] address;
        logic [63:0] payload;
        logic [3:0]  length;
        logic [31:0] sequence_num;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ADD_FIN,
        S_PICK,
        S_LOAD,
        S_LAST
    } state_t;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic emit_add;
        logic fetch;
        logic load;
        logic emit_last;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic scan_done;
        logic best_found;
        logic pend_valid;
        logic limit_hit;
        logic out_free;
    } sts_t;

    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/tcq_ctrl.sv -----
module tcq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tcq_pkg::sts_t   sts,
    output tcq_pkg::cmd_t   cmd
);
    import tcq_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.is_tick ? S_PICK : S_ADD_FIN;
                end
            end
            S_ADD_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PICK:
            begin
                if (sts.best_found)
                begin
                    state_next = S_LOAD;
                end
                else if (sts.pend_valid)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    state_next = sts.limit_hit ? S_LAST : S_SCAN;
                end
            end
            S_LAST:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.capture    = in_valid;
                cmd.start_scan = in_valid;
            end
            S_ADD_FIN:
            begin
                cmd.emit_add = sts.out_free;
            end
            S_PICK:
            begin
                cmd.fetch = sts.best_found;
            end
            S_LOAD:
            begin
                if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.load       = 1'b1;
                    cmd.start_scan = !sts.limit_hit;
                end
            end
            S_LAST:
            begin
                cmd.emit_last = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/tcq_datapath.sv -----
module tcq_datapath #(
    parameter int QUEUE_DEPTH       = tcq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_PAYLOAD_BYTES = tcq_pkg::DEF_MAX_PAYLOAD_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tcq_pkg::cmd_t   cmd,
    output tcq_pkg::sts_t   sts,
    input  logic            opcode,
    input  logic [31:0]     now_seconds,
    input  logic [31:0]     due_seconds,
    input  logic [15:0]     dest_address,
    input  logic [63:0]     payload,
    input  logic [3:0]      payload_length,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            result_kind,
    output logic [1:0]      add_status,
    output logic [15:0]     out_address,
    output logic [63:0]     out_payload,
    output logic [3:0]      out_length,
    output logic            last_released
);
    import tcq_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_reg;
    logic [IW-1:0] raddr;

    logic [QUEUE_DEPTH-1:0] valid_reg;
    logic [31:0] next_seq_reg;

    // captured word
    logic        op_reg;
    logic [31:0] now_reg, due_reg;
    logic [15:0] addr_reg;
    logic [63:0] pay_reg;
    logic [3:0]  len_reg;

    // scan pipeline
    logic          active_reg;
    logic [IW-1:0] idx_reg, pidx_reg;
    logic          pv_reg;

    logic          best_found_reg, free_found_reg;
    logic [IW-1:0] best_idx_reg, slot_reg;
    logic [31:0]   best_due_reg, best_age_reg;

    entry_t            pend_reg;
    logic              pend_valid_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic        out_valid_reg, kind_reg, last_reg;
    logic [1:0]  status_reg;
    logic [15:0] oaddr_reg;
    logic [63:0] opay_reg;
    logic [3:0]  olen_reg;

    logic        out_free;
    logic [31:0] age;
    logic        cand, better;
    logic [1:0]  add_code;
    entry_t      new_entry;

    assign out_free = !out_valid_reg || out_ready;
    assign raddr    = cmd.fetch ? best_idx_reg : idx_reg;
    assign age      = next_seq_reg - rd_reg.sequence_num;
    assign cand     = pv_reg && valid_reg[pidx_reg] && (rd_reg.due <= now_reg);
    assign better   = !best_found_reg || (rd_reg.due < best_due_reg) ||
                      ((rd_reg.due == best_due_reg) && (age > best_age_reg));

    always_comb
    begin
        if (due_reg <= now_reg)
        begin
            add_code = ST_PAST;
        end
        else if (!free_found_reg)
        begin
            add_code = ST_FULL;
        end
        else if (len_reg > 4'(MAX_PAYLOAD_BYTES))
        begin
            add_code = ST_TOO_LONG;
        end
        else
        begin
            add_code = ST_ACCEPTED;
        end
    end

    always_comb
    begin
        new_entry.due          = due_reg;
        new_entry.address      = addr_reg;
        new_entry.payload      = pay_reg & byte_mask(len_reg);
        new_entry.length       = len_reg;
        new_entry.sequence_num = next_seq_reg;
    end

    // read data holds the fetched entry until it is loaded
    always_ff @(posedge clk)
    begin
        if (active_reg || cmd.fetch)
        begin
            rd_reg <= mem[raddr];
        end
        if (cmd.emit_add && add_code == ST_ACCEPTED)
        begin
            mem[slot_reg] <= new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            now_reg  <= now_seconds;
            due_reg  <= due_seconds;
            addr_reg <= dest_address;
            pay_reg  <= payload;
            len_reg  <= payload_length;
        end
        if (cand && better)
        begin
            best_idx_reg <= pidx_reg;
            best_due_reg <= rd_reg.due;
            best_age_reg <= age;
        end
        if (pv_reg && !valid_reg[pidx_reg] && !free_found_reg)
        begin
            slot_reg <= pidx_reg;
        end
        if (cmd.load)
        begin
            pend_reg <= rd_reg;
        end
        if (cmd.emit_add)
        begin
            kind_reg   <= KIND_STATUS;
            status_reg <= add_code;
            oaddr_reg  <= '0;
            opay_reg   <= '0;
            olen_reg   <= '0;
            last_reg   <= 1'b0;
        end
        else if ((cmd.load && pend_valid_reg) || cmd.emit_last)
        begin
            kind_reg   <= KIND_RELEASE;
            status_reg <= ST_ACCEPTED;
            oaddr_reg  <= pend_reg.address;
            opay_reg   <= pend_reg.payload;
            olen_reg   <= pend_reg.length;
            last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            next_seq_reg   <= '0;
            active_reg     <= 1'b0;
            idx_reg        <= '0;
            pidx_reg       <= '0;
            pv_reg         <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start_scan)
            begin
                idx_reg        <= '0;
                active_reg     <= 1'b1;
                pv_reg         <= 1'b0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                pv_reg <= active_reg;
                if (active_reg)
                begin
                    pidx_reg <= idx_reg;
                    idx_reg  <= idx_reg + 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        active_reg <= 1'b0;
                    end
                end
                if (cand)
                begin
                    best_found_reg <= 1'b1;
                end
                if (pv_reg && !valid_reg[pidx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
            end

            if (cmd.capture)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.load)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.emit_add && add_code == ST_ACCEPTED)
            begin
                valid_reg[slot_reg] <= 1'b1;
                next_seq_reg        <= next_seq_reg + 32'd1;
            end
            if (cmd.fetch)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
            end

            if (cmd.load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.emit_last)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (cmd.emit_add || cmd.emit_last || (cmd.load && pend_valid_reg))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        sts.is_tick    = (op_reg == OP_TICK);
        sts.scan_done  = pv_reg && (pidx_reg == LAST_IDX);
        sts.best_found = best_found_reg;
        sts.pend_valid = pend_valid_reg;
        sts.limit_hit  = (cnt_reg == CNT_W'(RESULT_LIMIT - 1));
        sts.out_free   = out_free;
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = kind_reg;
    assign add_status    = status_reg;
    assign out_address   = oaddr_reg;
    assign out_payload   = opay_reg;
    assign out_length    = olen_reg;
    assign last_released = last_reg;

endmodule

// ----- hw/rtl/timed_command_queue_unit.sv -----
// Timed command queue: stores scheduled commands and releases them when due.
// Input channel (in_valid/in_ready) takes one word: opcode 0 adds a command
// (due time, group address, payload, length), opcode 1 is a tick carrying the
// current time. Output channel (out_valid/out_ready) returns result words.
// An add returns exactly one status word. A tick returns the due commands,
// earliest due time first, ties in insertion order, at most 16 per tick,
// the final one flagged by last_released; a tick with nothing due returns none.
// One word is worked on at a time; in_ready is high only when idle.
// Each store pass reads one entry per cycle from a single-port entry memory.
// Results wait in an output register; when the receiver stalls, the next
// release is held and the scan pauses until the register frees up.
// Reset empties the queue (valid bits cleared) and restarts the insertion
// counter; no clearing pass is needed, the block is ready right after reset.
module timed_command_queue_unit #(
    parameter int QUEUE_DEPTH       = tcq_pkg::DEF_QUEUE_DEPTH,
    parameter int MAX_PAYLOAD_BYTES = tcq_pkg::DEF_MAX_PAYLOAD_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [31:0] now_seconds,
    input  logic [31:0] due_seconds,
    input  logic [15:0] dest_address,
    input  logic [63:0] payload,
    input  logic [3:0]  payload_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [1:0]  add_status,
    output logic [15:0] out_address,
    output logic [63:0] out_payload,
    output logic [3:0]  out_length,
    output logic        last_released
);
    import tcq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tcq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcq_datapath #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (opcode),
        .now_seconds    (now_seconds),
        .due_seconds    (due_seconds),
        .dest_address   (dest_address),
        .payload        (payload),
        .payload_length (payload_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .add_status     (add_status),
        .out_address    (out_address),
        .out_payload    (out_payload),
        .out_length     (out_length),
        .last_released  (last_released)
    );

endmodule
